/* design/lavm_pkg.sv */
package lavm_pkg;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
    } t_in;

    typedef struct packed {
        logic        [1:0]  row_index;
        logic signed [31:0] col_0;
        logic signed [31:0] col_1;
        logic signed [31:0] col_2;
        logic               last_row;
        logic               degenerate;
    } t_out;

    typedef logic [2:0][31:0] t_vec32;
    typedef logic [2:0][63:0] t_vec64;

    // classified request waiting for the back end
    typedef struct packed {
        t_vec32           eye;
        t_vec32           up;
        logic [2:0][32:0] d;
        logic             fzero;
    } t_job;

    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_sts;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

endpackage

/* design/lavm_front.sv */
module lavm_front import lavm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_job_valid,
    input  logic i_job_ready,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       w_job;
    logic       push;
    logic       pop;

    always_comb begin
        w_job.eye[0] = i_data.eye_x;
        w_job.eye[1] = i_data.eye_y;
        w_job.eye[2] = i_data.eye_z;
        w_job.up[0]  = i_data.up_x;
        w_job.up[1]  = i_data.up_y;
        w_job.up[2]  = i_data.up_z;
        w_job.d[0]   = {i_data.target_x[31], i_data.target_x} - {i_data.eye_x[31], i_data.eye_x};
        w_job.d[1]   = {i_data.target_y[31], i_data.target_y} - {i_data.eye_y[31], i_data.eye_y};
        w_job.d[2]   = {i_data.target_z[31], i_data.target_z} - {i_data.eye_z[31], i_data.eye_z};
        w_job.fzero  = (w_job.d == '0);
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_cnt <= r_cnt + 2'd1;
            else if (pop && !push) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= w_job;
    end

endmodule

/* design/lavm_norm.sv */
module lavm_norm import lavm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_vec64    i_vec,
    output t_norm_sts o_sts,
    output t_vec32    o_res
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCALE = 6'b000010,
        S_SQ    = 6'b000100,
        S_ROOT  = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_nstate;

    t_nstate          r_state;
    logic [CW-1:0]    r_cnt;
    logic [63:0]      r_m [3];
    logic [2:0]       r_neg;
    logic             r_zero;
    logic [59:0]      r_prod;
    logic [63:0]      r_acc;
    logic [63:0]      r_s;
    logic [63:0]      r_res;
    logic [63:0]      r_bit;
    logic [31:0]      r_n;
    logic [32:0]      r_rem [3];
    logic [31:0]      r_q [3];

    logic [63:0]      or_all;
    logic [29:0]      sq;
    logic [63:0]      trial;
    logic             ge;
    logic [63:0]      n_res;
    logic [32:0]      dtrial [3];
    logic [2:0]       dge;

    always_comb begin
        or_all = r_m[0] | r_m[1] | r_m[2];
        case (r_cnt[1:0])
            2'd0:    sq = r_m[0][29:0];
            2'd1:    sq = r_m[1][29:0];
            default: sq = r_m[2][29:0];
        endcase
        trial = r_res + r_bit;
        ge    = (r_s >= trial);
        n_res = ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);
        for (int i = 0; i < 3; i++) begin
            dtrial[i] = (r_cnt == '0) ? r_rem[i] : {r_rem[i][31:0], 1'b0};
            dge[i]    = (dtrial[i] >= {1'b0, r_n});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_cnt <= '0;
                    if (or_all == 64'd0)                      r_state <= S_DONE;
                    else if (!(|or_all[63:30]) && or_all[29]) r_state <= S_SQ;
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[1:0] == 2'd3) r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= '0;
                    if (r_bit[0]) r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(FRAC_BITS)) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    for (int i = 0; i < 3; i++) begin
                        r_m[i]   <= mag64(i_vec[i]);
                        r_neg[i] <= i_vec[i][63];
                    end
                    r_zero <= 1'b0;
                end
            end
            S_SCALE: begin
                if (or_all == 64'd0) begin
                    r_zero <= 1'b1;
                end else if (|or_all[63:30]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (!or_all[29]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end
            end
            S_SQ: begin
                r_prod <= sq * sq;
                r_acc  <= (r_cnt[1:0] == 2'd0) ? 64'd0 : (r_acc + {4'd0, r_prod});
                r_s    <= r_acc + {4'd0, r_prod};
                r_res  <= 64'd0;
                r_bit  <= 64'd1 << 62;
            end
            S_ROOT: begin
                if (ge) r_s <= r_s - trial;
                r_res <= n_res;
                r_bit <= r_bit >> 2;
                r_n   <= n_res[31:0];
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= {2'd0, r_m[i][30:0]};
                    r_q[i]   <= 32'd0;
                end
            end
            S_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= dge[i] ? (dtrial[i] - {1'b0, r_n}) : dtrial[i];
                    r_q[i]   <= {r_q[i][30:0], dge[i]};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.done = (r_state == S_DONE);
        o_sts.zero = r_zero;
        for (int i = 0; i < 3; i++)
            o_res[i] = r_neg[i] ? (32'd0 - r_q[i]) : r_q[i];
    end

endmodule

/* design/lavm_back.sv */
module lavm_back import lavm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    output logic o_job_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam logic [63:0]        BIAS   = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic [31:0]        ONE    = 32'd1 << FRAC_BITS;
    localparam logic signed [63:0] MAX32  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] MIN32  = -64'sh0000_0000_8000_0000;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NF   = 7'b0000010,
        S_RC   = 7'b0000100,
        S_NR   = 7'b0001000,
        S_U    = 7'b0010000,
        S_T    = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_bstate;

    typedef enum logic [1:0] {
        D_RC = 2'd0,
        D_U  = 2'd1,
        D_T  = 2'd2
    } t_dest;

    function automatic logic [1:0] nxt3(input logic [1:0] i);
        case (i)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    t_bstate            r_state;
    logic [3:0]         r_cnt;
    logic [1:0]         r_tv;
    logic [1:0]         r_tc;
    logic [1:0]         r_row;
    logic               r_ovalid;
    t_out               r_out;
    t_vec32             r_eye;
    t_vec32             r_up;
    t_vec32             r_f;
    t_vec32             r_r;
    t_vec32             r_u;
    t_vec32             r_t;
    t_vec64             r_rc;
    logic               r_deg;

    logic               r_p1v;
    logic               r_p1sub;
    logic               r_p1first;
    logic               r_p1last;
    t_dest              r_p1dest;
    logic [1:0]         r_p1idx;
    logic signed [63:0] r_prod;
    logic               r_p2v;
    t_dest              r_p2dest;
    logic [1:0]         r_p2idx;
    logic [63:0]        r_acc;

    logic               iss;
    logic [31:0]        opa;
    logic [31:0]        opb;
    logic               isub;
    logic               ifirst;
    logic               ilast;
    t_dest              idest;
    logic [1:0]         iidx;
    logic [1:0]         ci;
    logic [1:0]         cj;
    logic [1:0]         ck;
    t_vec32             va;
    t_vec32             vb;
    logic [63:0]        sum;
    logic [63:0]        acc_b;
    logic signed [63:0] sh;
    logic [31:0]        sat;
    logic               norm_start;
    t_vec64             norm_vec;
    t_norm_sts          norm_sts;
    t_vec32             norm_res;
    logic               ld;
    t_out               row;

    lavm_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_vec   (norm_vec),
        .o_sts   (norm_sts),
        .o_res   (norm_res)
    );

    assign o_job_ready = (r_state == S_IDLE);
    assign norm_start  = ((r_state == S_IDLE) && i_job_valid && !i_job.fzero)
                       || ((r_state == S_RC) && (r_cnt == 4'd8));

    always_comb begin
        if (r_state == S_IDLE) begin
            for (int i = 0; i < 3; i++) norm_vec[i] = {{31{i_job.d[i][32]}}, i_job.d[i]};
        end else begin
            norm_vec = r_rc;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        ci     = r_cnt[2:1];
        cj     = nxt3(ci);
        ck     = nxt3(cj);
        va     = (r_state == S_RC) ? r_up : r_f;
        vb     = (r_state == S_RC) ? r_f : r_r;
        iss    = 1'b0;
        opa    = r_r[r_tc];
        opb    = r_eye[r_tc];
        isub   = 1'b1;
        ifirst = (r_tc == 2'd0);
        ilast  = (r_tc == 2'd2);
        idest  = D_T;
        iidx   = r_tv;
        if (r_state == S_RC || r_state == S_U) begin
            iss    = (r_cnt < 4'd6);
            opa    = r_cnt[0] ? va[ck] : va[cj];
            opb    = r_cnt[0] ? vb[cj] : vb[ck];
            isub   = r_cnt[0];
            ifirst = !r_cnt[0];
            ilast  = r_cnt[0];
            idest  = (r_state == S_RC) ? D_RC : D_U;
            iidx   = ci;
        end else if (r_state == S_T) begin
            iss = (r_cnt < 4'd9);
            case (r_tv)
                2'd0:    opa = r_r[r_tc];
                2'd1:    opa = r_u[r_tc];
                default: opa = r_f[r_tc];
            endcase
        end
    end

    always_comb begin
        if (r_p1first) sum = r_p1sub ? (64'd0 - r_prod) : r_prod;
        else           sum = r_p1sub ? (r_acc - r_prod) : (r_acc + r_prod);
        acc_b = r_acc + (r_acc[63] ? BIAS : 64'd0);
        sh    = $signed(acc_b) >>> FRAC_BITS;
        if (sh > MAX32)      sat = MAX32[31:0];
        else if (sh < MIN32) sat = MIN32[31:0];
        else                 sat = sh[31:0];
    end

    always_comb begin
        row.row_index  = r_row;
        row.last_row   = (r_row == 2'd3);
        row.degenerate = r_deg;
        if (r_deg) begin
            row.col_0 = (r_row == 2'd0) ? ONE : 32'd0;
            row.col_1 = (r_row == 2'd1) ? ONE : 32'd0;
            row.col_2 = (r_row == 2'd2) ? ONE : 32'd0;
        end else if (r_row == 2'd3) begin
            row.col_0 = r_t[0];
            row.col_1 = r_t[1];
            row.col_2 = r_t[2];
        end else begin
            row.col_0 = r_r[r_row];
            row.col_1 = r_u[r_row];
            row.col_2 = r_f[r_row];
        end
    end

    assign ld      = (r_state == S_OUT) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= 4'd0;
            r_tv     <= 2'd0;
            r_tc     <= 2'd0;
            r_row    <= 2'd0;
            r_ovalid <= 1'b0;
            r_p1v    <= 1'b0;
            r_p2v    <= 1'b0;
        end else begin
            r_p1v <= iss;
            r_p2v <= r_p1v && r_p1last;
            if (ld)           r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) r_state <= i_job.fzero ? S_OUT : S_NF;
                end
                S_NF: begin
                    r_cnt <= 4'd0;
                    if (norm_sts.done) r_state <= norm_sts.zero ? S_OUT : S_RC;
                end
                S_RC: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd8) r_state <= S_NR;
                end
                S_NR: begin
                    r_cnt <= 4'd0;
                    if (norm_sts.done) r_state <= norm_sts.zero ? S_OUT : S_U;
                end
                S_U: begin
                    r_tv  <= 2'd0;
                    r_tc  <= 2'd0;
                    if (r_cnt == 4'd5) begin
                        r_cnt   <= 4'd0;
                        r_state <= S_T;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_T: begin
                    r_cnt <= r_cnt + 4'd1;
                    if (iss) begin
                        if (r_tc == 2'd2) begin
                            r_tc <= 2'd0;
                            r_tv <= r_tv + 2'd1;
                        end else begin
                            r_tc <= r_tc + 2'd1;
                        end
                    end
                    if (r_cnt == 4'd11) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (ld) begin
                        r_row <= r_row + 2'd1;
                        if (r_row == 2'd3) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_job_valid) begin
            r_eye <= i_job.eye;
            r_up  <= i_job.up;
            r_deg <= i_job.fzero;
        end
        if ((r_state == S_NF) && norm_sts.done) begin
            r_f   <= norm_res;
            r_deg <= norm_sts.zero;
        end
        if ((r_state == S_NR) && norm_sts.done) begin
            r_r   <= norm_res;
            r_deg <= norm_sts.zero;
        end
        r_prod    <= $signed(opa) * $signed(opb);
        r_p1sub   <= isub;
        r_p1first <= ifirst;
        r_p1last  <= ilast;
        r_p1dest  <= idest;
        r_p1idx   <= iidx;
        if (r_p1v) r_acc <= sum;
        r_p2dest  <= r_p1dest;
        r_p2idx   <= r_p1idx;
        if (r_p2v) begin
            case (r_p2dest)
                D_RC:    r_rc[r_p2idx] <= r_acc;
                D_U:     r_u[r_p2idx]  <= sh[31:0];
                default: r_t[r_p2idx]  <= sat;
            endcase
        end
        if (ld) r_out <= row;
    end

endmodule

/* design/look_at_view_matrix.sv */
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data   (t_in)
// out       output     o_out_valid / i_out_ready  o_out_data  (t_out, four rows per request)
//
// A request yields four rows. Normal requests pass through the shared normalizer twice, once for
// the forward vector and once for the right vector; each pass runs 1-bit shift steps, a sum of
// squares, a 32-step root and a FRAC_BITS+1 step divide. Target equal to eye skips the normalizer.
// Reset is synchronous, active low, and clears control state only.
// A two-entry queue takes requests while the back end works; rows stall in the output register.
module look_at_view_matrix import lavm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic job_valid;
    logic job_ready;
    t_job job;

    lavm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    lavm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .o_job_ready (job_ready),
        .i_job       (job),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule
